// ===== sv/fpga_serial_config_loader_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial configuration loader
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FPGA_SERIAL_CONFIG_LOADER_TOP_DEFINES_SVH
`define FPGA_SERIAL_CONFIG_LOADER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FSCL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FSCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/fscl_pkg.sv =====
// ----------------------------------------------------------------------------
// fscl_pkg
// Shared types and constants of the serial configuration loader.
// ----------------------------------------------------------------------------
package fscl_pkg;

   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   // Register indexes, taken from the word address bit
   localparam logic REG_COMPRESS_ENABLE = 1'b0;
   localparam logic REG_IMAGE_LENGTH    = 1'b1;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // Classified input item
   typedef struct packed {
      logic       start;
      logic       status_ready;
      logic       byte_valid;
      logic [7:0] byte_value;
   } item_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic        compress_enable;
      logic [31:0] image_length;
   } cfg_type;

   typedef struct packed {
      logic bit_valid;
      logic data_bit;
      logic byte_request;
      logic done_res;
   } result_type;

endpackage

// ===== sv/fscl_front.sv =====
// ----------------------------------------------------------------------------
// fscl_front
// Accepts and classifies input items into a two-entry queue.
// ----------------------------------------------------------------------------
module fscl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic               req_status_ready,
   input  logic               req_byte_valid,
   input  logic [7:0]         req_byte_value,
   output fscl_pkg::head_type head,
   input  logic               pop
);
   import fscl_pkg::*;

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_in;

   // Full queue holds the input side
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      item_in.start        = req_kind;
      item_in.status_ready = req_status_ready;
      item_in.byte_valid   = req_byte_valid;
      item_in.byte_value   = req_byte_value;
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== sv/fscl_back.sv =====
// ----------------------------------------------------------------------------
// fscl_back
// Runs the loader for one queued item a cycle into a free output register.
// ----------------------------------------------------------------------------
module fscl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fscl_pkg::cfg_type    cfg,
   input  fscl_pkg::head_type   head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fscl_pkg::result_type rsp
);
   import fscl_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_RUN  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [31:0] src_left_ff, src_left_in;
   logic [7:0]  zero_run_ff, zero_run_in;
   logic        await_count_ff, await_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        fire;

   // Take the head when the output register is empty or being drained
   assign fire = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = fire;

   always_comb begin
      phase_in       = phase_ff;
      src_left_in    = src_left_ff;
      zero_run_in    = zero_run_ff;
      await_count_in = await_count_ff;
      shift_byte_in  = shift_byte_ff;
      bits_left_in   = bits_left_ff;
      rsp_in         = '0;

      if (head.item.start) begin
         phase_in       = PH_WAIT;
         src_left_in    = cfg.image_length;
         zero_run_in    = 8'd0;
         await_count_in = 1'b0;
         shift_byte_in  = 8'd0;
         bits_left_in   = 4'd0;
      end else if (phase_ff == PH_WAIT) begin
         if (head.item.status_ready) begin
            phase_in = PH_RUN;
         end
      end else if (phase_ff == PH_RUN) begin
         if (bits_left_ff == 4'd0) begin
            if (zero_run_ff != 8'd0) begin
               zero_run_in   = zero_run_ff - 8'd1;
               shift_byte_in = 8'd0;
               bits_left_in  = BITS_PER_BYTE;
            end else if (src_left_ff != 32'd0 && head.item.byte_valid) begin
               src_left_in = src_left_ff - 32'd1;
               if (await_count_ff) begin
                  // count byte: the leading zero byte already went out
                  await_count_in = 1'b0;
                  if (head.item.byte_value > 8'd1) begin
                     zero_run_in   = head.item.byte_value - 8'd2;
                     shift_byte_in = 8'd0;
                     bits_left_in  = BITS_PER_BYTE;
                  end
               end else begin
                  if (cfg.compress_enable && head.item.byte_value == 8'd0 &&
                      src_left_ff != 32'd1) begin
                     await_count_in = 1'b1;
                  end
                  shift_byte_in = head.item.byte_value;
                  bits_left_in  = BITS_PER_BYTE;
               end
            end
         end
         if (bits_left_in != 4'd0) begin
            rsp_in.bit_valid = 1'b1;
            rsp_in.data_bit  = shift_byte_in[0];
            shift_byte_in    = {1'b0, shift_byte_in[7:1]};
            bits_left_in     = bits_left_in - 4'd1;
         end
      end

      if (phase_in == PH_RUN && bits_left_in == 4'd0 && zero_run_in == 8'd0) begin
         if (src_left_in != 32'd0) begin
            rsp_in.byte_request = 1'b1;
         end else if (!await_count_in) begin
            phase_in = PH_DONE;
         end
      end
      rsp_in.done_res = (phase_in == PH_DONE);
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         src_left_ff    <= 32'd0;
         zero_run_ff    <= 8'd0;
         await_count_ff <= 1'b0;
         shift_byte_ff  <= 8'd0;
         bits_left_ff   <= 4'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff       <= phase_in;
            src_left_ff    <= src_left_in;
            zero_run_ff    <= zero_run_in;
            await_count_ff <= await_count_in;
            shift_byte_ff  <= shift_byte_in;
            bits_left_ff   <= bits_left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sv/fpga_serial_config_loader_top.sv =====
// ----------------------------------------------------------------------------
// fpga_serial_config_loader_top
// Passive serial configuration loader with zero run-length expansion.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  req_*     in         req_valid/req_stall  kind, status_ready, byte_valid,
//                                            byte_value
//  rsp_*     out        rsp_valid/rsp_stall  bit_valid, data_bit,
//                                            byte_request, done_res
//  APB       in/out     psel/penable/pready  compress_enable @0x0,
//                                            image_length @0x4
//
//  One item per cycle is sustained while rsp_stall is low; an accepted item is
//  written into the queue and then into the output register.
//  The loader state update (32-bit source count decrement and compare) is the
//  combinational step in the back end that runs for each item taken.
//  Reset (synchronous, active high) empties the queue, clears the output
//  valid flag and returns the loader to idle with both registers at zero.
//  A stalled result holds in the output register while the two-entry queue
//  keeps taking items; req_stall rises only when the queue is full.
//
module fpga_serial_config_loader_top (
   input  logic                        clock,
   input  logic                        reset,
   // input item channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic                        req_status_ready,
   input  logic                        req_byte_valid,
   input  logic [7:0]                  req_byte_value,
   // result item channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_bit_valid,
   output logic                        rsp_data_bit,
   output logic                        rsp_byte_request,
   output logic                        rsp_done_res,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fscl_pkg::ADDR_W-1:0] paddr,
   input  logic [fscl_pkg::DATA_W-1:0] pwdata,
   output logic [fscl_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import fscl_pkg::*;

   logic        compress_enable_ff, compress_enable_in;
   logic [31:0] image_length_ff, image_length_in;
   logic        reg_write;
   logic        reg_index;
   cfg_type     cfg;
   head_type    head;
   logic        pop;
   result_type  rsp;

   // Register port: no wait states, write lands in the access phase
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready;
   // Word index from the byte address
   assign reg_index = paddr[2];

   always_comb begin
      compress_enable_in = compress_enable_ff;
      image_length_in    = image_length_ff;
      if (reg_write) begin
         unique case (reg_index)
            REG_COMPRESS_ENABLE: compress_enable_in = pwdata[0];
            REG_IMAGE_LENGTH:    image_length_in    = pwdata;
            default:             compress_enable_in = compress_enable_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_COMPRESS_ENABLE: prdata = {{(DATA_W-1){1'b0}}, compress_enable_ff};
         REG_IMAGE_LENGTH:    prdata = image_length_ff;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_enable_ff <= 1'b0;
         image_length_ff    <= 32'd0;
      end else begin
         compress_enable_ff <= compress_enable_in;
         image_length_ff    <= image_length_in;
      end
   end

   assign cfg.compress_enable = compress_enable_ff;
   assign cfg.image_length    = image_length_ff;

   // Front end: classify and queue items
   fscl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_status_ready (req_status_ready),
      .req_byte_valid   (req_byte_valid),
      .req_byte_value   (req_byte_value),
      .head             (head),
      .pop              (pop)
   );

   // Back end: advance the loader and register the result
   fscl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_bit_valid    = rsp.bit_valid;
   assign rsp_data_bit     = rsp.data_bit;
   assign rsp_byte_request = rsp.byte_request;
   assign rsp_done_res     = rsp.done_res;

endmodule

// ===== sv/fscl_checker.sv =====
// ----------------------------------------------------------------------------
// fscl_checker
// Port-level checks of the serial configuration loader.
// ----------------------------------------------------------------------------
`include "fpga_serial_config_loader_top_defines.svh"

module fscl_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_bit_valid,
   input logic rsp_data_bit,
   input logic rsp_byte_request,
   input logic rsp_done_res
);

   // A stalled item holds
   `FSCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_bit_valid, rsp_data_bit, rsp_byte_request, rsp_done_res}), "stalled result item changed")

   // No data bit without a bit strobe
   `FSCL_ASSERT_NOW(a_bit_quiet, rsp_valid && !rsp_bit_valid, !rsp_data_bit, "data bit set without bit_valid")

   // A finished job asks for no more bytes
   `FSCL_ASSERT_NOW(a_done_no_req, rsp_valid && rsp_done_res, !rsp_byte_request, "byte request after done")

   // Nothing comes out the cycle after reset
   `FSCL_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind fpga_serial_config_loader_top fscl_checker u_fscl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_bit_valid    (rsp_bit_valid),
   .rsp_data_bit     (rsp_data_bit),
   .rsp_byte_request (rsp_byte_request),
   .rsp_done_res     (rsp_done_res)
);
